@@ hdl/u8wo_pkg.sv @@
// Package for the UTF-8 wrap-opportunity detector.
// Holds the per-string state type, character codes and the byte decode functions.
// Used by u8wo_step and utf8_wrap_opportunity_detector; depends on nothing.
`timescale 1ns / 1ps

package u8wo_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CP_W   = 21;

	localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'he0;
	localparam logic [BYTE_W-1:0] LEAD2_PAT  = 8'hc0;
	localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hf0;
	localparam logic [BYTE_W-1:0] LEAD3_PAT  = 8'he0;
	localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hf8;
	localparam logic [BYTE_W-1:0] LEAD4_PAT  = 8'hf0;

	localparam logic [CP_W-1:0] CP_TAB     = 21'h00009;
	localparam logic [CP_W-1:0] CP_NEWLINE = 21'h0000a;
	localparam logic [CP_W-1:0] CP_SPACE   = 21'h00020;
	localparam logic [CP_W-1:0] CP_HYPHEN  = 21'h0002d;
	localparam logic [CP_W-1:0] CP_SLASH   = 21'h0002f;

	localparam logic [CP_W-1:0] CJK_EXT_A_LO  = 21'h03400;
	localparam logic [CP_W-1:0] CJK_EXT_A_HI  = 21'h04dbf;
	localparam logic [CP_W-1:0] CJK_UNIF_LO   = 21'h04e00;
	localparam logic [CP_W-1:0] CJK_UNIF_HI   = 21'h09fff;
	localparam logic [CP_W-1:0] CJK_COMPAT_LO = 21'h0f900;
	localparam logic [CP_W-1:0] CJK_COMPAT_HI = 21'h0faff;

	localparam logic [1:0] CJK_SAT = 2'd2;

	typedef struct packed {
		logic [2:0][BYTE_W-1:0] pend;
		logic [1:0]             cnt;
		logic [1:0]             cjk;
		logic                   found;
	} u8wo_state_t;

	function automatic logic [2:0] lead_width(input logic [BYTE_W-1:0] b);
		logic [2:0] w;
		if ((b & LEAD2_MASK) == LEAD2_PAT) begin
			w = 3'd2;
		end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
			w = 3'd3;
		end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
			w = 3'd4;
		end else begin
			w = 3'd1;
		end
		return w;
	endfunction

	function automatic logic [CP_W-1:0] decode_seq(input logic [BYTE_W-1:0] b0,
		input logic [BYTE_W-1:0] b1, input logic [BYTE_W-1:0] b2,
		input logic [BYTE_W-1:0] b3, input logic [2:0] w);
		logic [CP_W-1:0] cp;
		case (w)
			3'd2: begin
				cp = {10'd0, b0[4:0], b1[5:0]};
			end
			3'd3: begin
				cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
			end
			3'd4: begin
				cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
			end
			default: begin
				cp = {13'd0, b0};
			end
		endcase
		return cp;
	endfunction

	function automatic logic is_break(input logic [CP_W-1:0] cp);
		return (cp == CP_SPACE) || (cp == CP_TAB) || (cp == CP_NEWLINE) ||
			(cp == CP_HYPHEN) || (cp == CP_SLASH);
	endfunction

	function automatic logic is_cjk(input logic [CP_W-1:0] cp);
		return ((cp >= CJK_EXT_A_LO) && (cp <= CJK_EXT_A_HI)) ||
			((cp >= CJK_UNIF_LO) && (cp <= CJK_UNIF_HI)) ||
			((cp >= CJK_COMPAT_LO) && (cp <= CJK_COMPAT_HI));
	endfunction

endpackage

@@ hdl/u8wo_step.sv @@
// Next-state logic for one word of the UTF-8 wrap-opportunity detector.
// Gathers bytes into code points, classifies them, and replays cut-short bytes at string end.
// Depends on u8wo_pkg.
`timescale 1ns / 1ps

module u8wo_step (
	input  u8wo_pkg::u8wo_state_t st,
	input  logic [7:0]            data_byte,
	input  logic                  no_byte,
	input  logic                  end_of_string,
	output u8wo_pkg::u8wo_state_t nxt,
	output logic                  wrap_possible
);

	import u8wo_pkg::*;

	logic [1:0]        n;
	logic [2:0]        n1;
	logic [2:0]        w;
	logic              push;
	logic              done;
	logic [BYTE_W-1:0] buf0, buf1, buf2;
	logic [CP_W-1:0]   cp;
	logic [1:0]        cjk_a;
	logic              found_a;
	logic [2:0][BYTE_W-1:0] pend_a;
	logic [1:0]        cnt_a;
	logic [CP_W-1:0]   cp2;
	logic              rep;

	always_comb begin
		n    = st.cnt;
		n1   = {1'b0, n} + 3'd1;
		push = !no_byte;
		buf0 = (n == 2'd0) ? data_byte : st.pend[0];
		buf1 = (n == 2'd1) ? data_byte : st.pend[1];
		buf2 = (n == 2'd2) ? data_byte : st.pend[2];
		w    = lead_width(buf0);
		done = push && (n1 >= w);
		cp   = decode_seq(buf0, buf1, buf2, data_byte, w);

		cjk_a   = st.cjk;
		found_a = st.found;
		if (done) begin
			if (is_break(cp)) begin
				found_a = 1'b1;
			end
			if (is_cjk(cp)) begin
				cjk_a = (st.cjk == CJK_SAT) ? CJK_SAT : st.cjk + 2'd1;
				if (cjk_a == CJK_SAT) begin
					found_a = 1'b1;
				end
			end
		end

		pend_a = st.pend;
		cnt_a  = n;
		if (push) begin
			if (done) begin
				cnt_a = 2'd0;
			end else begin
				if (n != 2'd3) begin
					pend_a[n] = data_byte;
				end
				cnt_a = n1[1:0];
			end
		end

		// At string end the lead falls back to a single byte; the bytes after it decode again.
		cp2 = decode_seq(pend_a[1], pend_a[2], 8'd0, 8'd0, 3'd2);
		rep = 1'b0;
		if (cnt_a == 2'd3 && lead_width(pend_a[1]) == 3'd2) begin
			rep = is_break(cp2);
		end else if (cnt_a >= 2'd2) begin
			rep = is_break({13'd0, pend_a[1]}) ||
				((cnt_a == 2'd3) && is_break({13'd0, pend_a[2]}));
		end

		wrap_possible = found_a || rep;

		nxt.pend = pend_a;
		if (end_of_string) begin
			nxt.cnt   = 2'd0;
			nxt.cjk   = 2'd0;
			nxt.found = 1'b0;
		end else begin
			nxt.cnt   = cnt_a;
			nxt.cjk   = cjk_a;
			nxt.found = found_a;
		end
	end

endmodule

@@ hdl/utf8_wrap_opportunity_detector.sv @@
// A word is registered in the input stage on acceptance; a string-end word is held there until
// the output register is free. Throughput: one word per cycle unless a word is held so;
// the per-string state is updated by one level of decode logic.
// Reset (arst_n low) clears the valid flags, the byte count, the CJK count and the found flag;
// the stored bytes are not reset and are only read below the byte count.
// Top level; depends on u8wo_pkg and u8wo_step.
`timescale 1ns / 1ps

module utf8_wrap_opportunity_detector (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] data_byte
	input  logic [0:0] s_tuser,  // [0] no_byte
	input  logic       s_tlast,  // end_of_string
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata   // [0] wrap_possible, [7:1] zero
);

	import u8wo_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] data_s1;
	logic              none_s1;
	logic              last_s1;
	logic [2:0][BYTE_W-1:0] pend_q;
	logic [1:0]        cnt_q;
	logic [1:0]        cjk_q;
	logic              found_q;
	logic              m_valid_q;
	logic              wrap_q;
	logic              out_free;
	logic              s1_go;
	logic              in_fire;
	u8wo_state_t       st;
	u8wo_state_t       nxt;
	logic              wrap_nxt;

	assign out_free = !m_valid_q || m_tready;
	assign s1_go    = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || s1_go;
	assign in_fire  = s_tvalid && s_tready;

	assign st.pend  = pend_q;
	assign st.cnt   = cnt_q;
	assign st.cjk   = cjk_q;
	assign st.found = found_q;

	u8wo_step u_step (
		.st            (st),
		.data_byte     (data_s1),
		.no_byte       (none_s1),
		.end_of_string (last_s1),
		.nxt           (nxt),
		.wrap_possible (wrap_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			cnt_q     <= 2'd0;
			cjk_q     <= 2'd0;
			found_q   <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			if (s1_go) begin
				cnt_q   <= nxt.cnt;
				cjk_q   <= nxt.cjk;
				found_q <= nxt.found;
			end
			if (s1_go && last_s1) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_s1 <= s_tdata;
			none_s1 <= s_tuser[0];
			last_s1 <= s_tlast;
		end
		if (s1_go) begin
			pend_q <= nxt.pend;
		end
		if (s1_go && last_s1) begin
			wrap_q <= wrap_nxt;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'd0, wrap_q};

`ifndef SYNTHESIS
	a_pend_lead: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != 2'd0) |-> (lead_width(pend_q[0]) > {1'b0, cnt_q}))
		else $error("pending bytes do not start with an incomplete lead");

	a_cjk_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(cjk_q != 2'd3))
		else $error("CJK count went past saturation");

	a_cjk_found: assert property (@(posedge clk) disable iff (!arst_n)
		(cjk_q == CJK_SAT) |-> found_q)
		else $error("second CJK ideograph did not set the found flag");

	a_end_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && last_s1) |=> (cnt_q == 2'd0 && cjk_q == 2'd0 && !found_q && m_valid_q))
		else $error("string end did not clear state and post a result");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !m_tready) |-> !(s1_go && last_s1))
		else $error("result register overwritten while stalled");
`endif

endmodule
